[rtl/core/utf8_stream_decoder_core_macros.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define U8SD_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("u8sd assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define U8SD_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("u8sd assertion failed");

`else

`define U8SD_ASSERT_IMP(lbl, ant, cons)
`define U8SD_ASSERT_NXT(lbl, ant, cons)

`endif

`endif

[rtl/core/u8sd_pkg.sv]
// Types and constants shared by the UTF-8 stream decoder modules.
`default_nettype none

package u8sd_pkg;

	localparam int ByteW     = 8;
	localparam int CpW       = 36;
	localparam int LenW      = 3;
	localparam int ContDataW = 6;

	// A code point of a multi-byte sequence below this limit is overlong.
	localparam logic [CpW-1:0] AsciiLimit = CpW'(128);
	// Value that replaces an overlong multi-byte code point.
	localparam logic [CpW-1:0] OverlongCp = CpW'(8'h20);

	// Byte class tags: bit 7 clear is a one-byte sequence, 10xxxxxx is a continuation.
	localparam logic [1:0] ContTag = 2'b10;

	// Classification of one raw byte.
	typedef struct packed {
		logic                 is_ascii;
		logic                 is_cont;
		logic [LenW-1:0]      seq_len;
		logic [ContDataW-1:0] lead_data;
	} lead_info_t;

endpackage

`default_nettype wire

[rtl/core/utf8_stream_decoder_core.sv]
// Top level of the byte-serial UTF-8 stream decoder.
//
// Usage: raw bytes enter on the in_* channel, one per beat; decoded code points
// leave on the out_* channel. A beat moves when valid is high and stall is low.
// A one-byte sequence gives a result for its own beat. A multi-byte sequence
// gives one result with the beat of its last continuation byte; the lead and
// middle bytes give none. A malformed byte gives an error result (code point 0,
// length 0) and is dropped; decoding restarts with the next byte.
// A result is registered: it appears on out_* in the cycle after the input beat
// that completes it. Throughput: one byte per cycle unless the receiver stalls
// on a held result, set by the state register (counters and 36-bit accumulator).
// Reset clears the sequence state and empties the result register.
// While the receiver stalls with a result waiting, in_stall is raised and the
// held result stays unchanged; when the result is taken, a new byte can be
// accepted in the same cycle.
`default_nettype none

`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [u8sd_pkg::ByteW-1:0] in_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [u8sd_pkg::CpW-1:0]        code_point,
	output logic [u8sd_pkg::LenW-1:0]       seq_length,
	output logic                            decode_error
);
	import u8sd_pkg::*;

	lead_info_t     info;
	logic           in_accept;

	logic [LenW-1:0] bytes_left_q;
	logic [LenW-1:0] total_bytes_q;
	logic [CpW-1:0]  acc_q;

	logic [LenW-1:0] bytes_left_d;
	logic [LenW-1:0] total_bytes_d;
	logic [CpW-1:0]  acc_d;
	logic [CpW-1:0]  acc_shift;

	logic            emit;
	logic [CpW-1:0]  cp_d;
	logic [LenW-1:0] len_d;
	logic            err_d;

	logic            out_valid_q;
	logic [CpW-1:0]  code_point_q;
	logic [LenW-1:0] seq_length_q;
	logic            decode_error_q;

	u8sd_lead_dec u_lead_dec (
		.byte_in (in_byte),
		.info    (info)
	);

	// Accept whenever the result register is empty or being emptied.
	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	assign acc_shift = {acc_q[CpW-ContDataW-1:0], in_byte[ContDataW-1:0]};

	// Next sequence state and the result caused by the current byte.
	always_comb begin
		bytes_left_d  = bytes_left_q;
		total_bytes_d = total_bytes_q;
		acc_d         = acc_q;
		emit          = 1'b0;
		cp_d          = '0;
		len_d         = '0;
		err_d         = 1'b0;
		if (bytes_left_q == '0) begin
			if (info.is_ascii) begin
				emit  = 1'b1;
				cp_d  = CpW'(in_byte);
				len_d = LenW'(1);
			end else if (info.is_cont) begin
				emit  = 1'b1;
				err_d = 1'b1;
			end else begin
				acc_d         = CpW'(info.lead_data);
				total_bytes_d = info.seq_len;
				bytes_left_d  = info.seq_len - LenW'(1);
			end
		end else if (!info.is_cont) begin
			bytes_left_d  = '0;
			total_bytes_d = '0;
			acc_d         = '0;
			emit          = 1'b1;
			err_d         = 1'b1;
		end else begin
			bytes_left_d = bytes_left_q - LenW'(1);
			if (bytes_left_d == '0) begin
				emit          = 1'b1;
				cp_d          = (acc_shift < AsciiLimit) ? OverlongCp : acc_shift;
				len_d         = total_bytes_q;
				total_bytes_d = '0;
				acc_d         = '0;
			end else begin
				acc_d = acc_shift;
			end
		end
	end

	// Sequence state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			total_bytes_q <= '0;
			acc_q         <= '0;
		end else if (in_accept) begin
			bytes_left_q  <= bytes_left_d;
			total_bytes_q <= total_bytes_d;
			acc_q         <= acc_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			code_point_q   <= cp_d;
			seq_length_q   <= len_d;
			decode_error_q <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_point   = code_point_q;
	assign seq_length   = seq_length_q;
	assign decode_error = decode_error_q;

	// Checks on the decoder's own logic.
	`U8SD_ASSERT_IMP(a_err_payload, out_valid && decode_error, code_point == '0 && seq_length == '0)
	`U8SD_ASSERT_IMP(a_multi_not_overlong, out_valid && !decode_error && seq_length > LenW'(1), code_point >= OverlongCp)
	`U8SD_ASSERT_IMP(a_left_below_total, bytes_left_q != '0, bytes_left_q < total_bytes_q)
	`U8SD_ASSERT_NXT(a_ascii_result, in_accept && bytes_left_q == '0 && !in_byte[ByteW-1], out_valid && seq_length == LenW'(1) && !decode_error)
	`U8SD_ASSERT_IMP(a_stall_needs_result, in_stall, out_valid)

endmodule

`default_nettype wire

[rtl/core/u8sd_lead_dec.sv]
// Byte classifier: byte class, sequence length and data bits of a lead byte.
`default_nettype none

module u8sd_lead_dec (
	input  wire logic [u8sd_pkg::ByteW-1:0] byte_in,
	output u8sd_pkg::lead_info_t            info
);
	import u8sd_pkg::*;

	logic [LenW-1:0]      run_len;
	logic                 run;
	logic [LenW-1:0]      data_bits;
	logic [ContDataW-1:0] data_mask;

	// Count the run of ones from bit 6 down to bit 1; the length is one more.
	always_comb begin
		run_len = LenW'(1);
		run     = 1'b1;
		for (int i = ByteW - 2; i >= 1; i--) begin
			if (run && byte_in[i]) begin
				run_len = run_len + LenW'(1);
			end else begin
				run = 1'b0;
			end
		end
	end

	// The lead keeps 7 - length data bits below its marker.
	assign data_bits = LenW'(7) - run_len;
	assign data_mask = ContDataW'((7'd1 << data_bits) - 7'd1);

	assign info.is_ascii  = ~byte_in[ByteW-1];
	assign info.is_cont   = (byte_in[ByteW-1 -: 2] == ContTag);
	assign info.seq_len   = run_len;
	assign info.lead_data = byte_in[ContDataW-1:0] & data_mask;

endmodule

`default_nettype wire

[verif/utf8_stream_decoder_core_tb.sv]
// Testbench for the UTF-8 stream decoder core: a directed byte table, then random byte streams.
module utf8_stream_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8sd_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int DIRECTED_ROWS = 25;
	localparam int DRAIN_CYCLES = 10;

	// Values of the decode_error field.
	localparam logic DEC_OK  = 1'b0;
	localparam logic DEC_BAD = 1'b1;

	// Whether a stimulus row carries its expectation written out or leaves it to the decoder model.
	localparam logic EXP_GIVEN   = 1'b1;
	localparam logic EXP_PREDICT = 1'b0;

	// One decoded code point as it leaves the block.
	typedef struct packed {
		logic [CpW-1:0]  cp;
		logic [LenW-1:0] len;
		logic            err;
	} decoded_t;

	// One input byte, with an optional expectation written out.
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             given;
		logic             has_out;
		logic [CpW-1:0]   cp;
		logic [LenW-1:0]  len;
		logic             err;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [ByteW-1:0] in_byte = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [CpW-1:0]   code_point;
	logic [LenW-1:0]  seq_length;
	logic             decode_error;

	// Decoder model state: continuation bytes still due, sequence length, gathered bits.
	logic [LenW-1:0] seq_left = '0;
	logic [LenW-1:0] seq_total = '0;
	logic [CpW-1:0]  seq_acc = '0;

	stim_row_t byte_q[$];
	decoded_t  pending_decodes[$];
	stim_row_t directed_rows [DIRECTED_ROWS];
	stim_row_t cur_row = '0;
	stim_row_t next_row;
	decoded_t  predicted;
	decoded_t  want;
	bit        produced;
	int        bytes_queued = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        error_count = 0;
	int        cycle_count = 0;

	utf8_stream_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.seq_length   (seq_length),
		.decode_error (decode_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Feed one byte through the decoder model; returns 1 when the byte completes a result.
	function automatic bit decode_byte(input logic [ByteW-1:0] b, output decoded_t res);
		int run;
		int n;
		res = '{'0, '0, DEC_BAD};
		if (seq_left == 0) begin
			if (!b[7]) begin
				res = '{CpW'(b), LenW'(1), DEC_OK};
				return 1'b1;
			end
			if (b[7:6] == ContTag) begin
				return 1'b1;
			end
			// The run of ones below bit 7 sets the length; the rest of the lead is data.
			run = 0;
			for (n = 6; n > 0 && b[n]; n--) begin
				run++;
			end
			seq_acc = CpW'(b & ((1 << (6 - run)) - 1));
			seq_total = LenW'(run + 1);
			seq_left = LenW'(run);
			return 1'b0;
		end
		// Anything but a continuation byte abandons the sequence and is dropped.
		if (b[7:6] != ContTag) begin
			seq_left = '0;
			seq_total = '0;
			seq_acc = '0;
			return 1'b1;
		end
		seq_acc = {seq_acc[CpW-7:0], b[5:0]};
		seq_left = seq_left - 1'b1;
		if (seq_left != 0) begin
			return 1'b0;
		end
		// A multi-byte value that would fit in one byte is overlong.
		res = '{(seq_acc < AsciiLimit) ? OverlongCp : seq_acc, seq_total, DEC_OK};
		seq_total = '0;
		seq_acc = '0;
		return 1'b1;
	endfunction

	task automatic queue_byte(input logic [ByteW-1:0] b);
		byte_q.push_back('{b, EXP_PREDICT, 1'b0, '0, '0, DEC_OK});
		bytes_queued++;
	endtask

	// Queue a sequence of len bytes, cut off after keep bytes by a non-continuation byte.
	task automatic queue_sequence(input int len, input bit low_value, input int keep);
		logic [ByteW-1:0] lead;
		logic [ByteW-1:0] data_mask;
		int k;
		if (len == 1) begin
			queue_byte(8'($urandom_range(0, 127)));
			return;
		end
		data_mask = (len == 7) ? 8'h00 : 8'((1 << (7 - len)) - 1);
		lead = 8'(8'hFF << (8 - len));
		if (low_value) begin
			lead = lead | ((len == 2) ? 8'($urandom_range(0, 1)) : 8'h00);
		end else begin
			lead = lead | (8'($urandom) & data_mask);
		end
		if (len == 7) begin
			lead[0] = 1'($urandom_range(0, 1));
		end
		queue_byte(lead);
		for (k = 1; k < keep; k++) begin
			if (low_value && k < len - 1) begin
				queue_byte(8'h80);
			end else begin
				queue_byte(8'h80 | 8'($urandom_range(0, 63)));
			end
		end
		if (keep < len) begin
			case ($urandom_range(0, 2))
				0: begin
					queue_byte(8'($urandom_range(0, 127)));
				end
				1: begin
					queue_byte(8'hC0 | 8'($urandom_range(0, 63)));
				end
				default: begin
					queue_byte(8'h00);
				end
			endcase
		end
	endtask

	// Mostly well-formed sequences, with overlong values, cut sequences, strays and noise mixed in.
	task automatic queue_random(input int count);
		int start;
		int pick;
		int len;
		start = bytes_queued;
		while (bytes_queued - start < count) begin
			pick = $urandom_range(99);
			len = ($urandom_range(99) < 40) ? $urandom_range(1, 3) : $urandom_range(1, 7);
			if (pick < 70) begin
				queue_sequence(len, 1'b0, len);
			end else if (pick < 80) begin
				len = (len < 2) ? 2 : len;
				queue_sequence(len, 1'b1, len);
			end else if (pick < 90) begin
				len = (len < 2) ? 2 : len;
				queue_sequence(len, 1'b0, $urandom_range(1, len - 1));
			end else if (pick < 95) begin
				queue_byte(8'h80 | 8'($urandom_range(0, 63)));
			end else begin
				queue_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random(count);
		while (byte_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Sender: on each accepted beat, predict its result; then offer the next byte or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				produced = decode_byte(cur_row.data, predicted);
				if (cur_row.given) begin
					if (cur_row.has_out) begin
						pending_decodes.push_back('{cur_row.cp, cur_row.len, cur_row.err});
					end
				end else if (produced) begin
					pending_decodes.push_back(predicted);
				end
			end
			if (!(in_valid && in_stall)) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_row = byte_q.pop_front();
					cur_row <= next_row;
					in_byte <= next_row.data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each accepted beat with the oldest expected result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_decodes.size() == 0) begin
					$error("unexpected result: code_point %h seq_length %0d decode_error %0b",
						code_point, seq_length, decode_error);
					error_count++;
				end else begin
					want = pending_decodes.pop_front();
					if (code_point !== want.cp) begin
						$error("code_point: expected %h, got %h", want.cp, code_point);
						error_count++;
					end
					if (seq_length !== want.len) begin
						$error("seq_length: expected %0d, got %0d", want.len, seq_length);
						error_count++;
					end
					if (decode_error !== want.err) begin
						$error("decode_error: expected %0b, got %0b", want.err, decode_error);
						error_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		directed_rows = '{
			'{8'h00, EXP_GIVEN, 1'b1, 36'h0, 3'd1, DEC_OK},
			'{8'h7F, EXP_GIVEN, 1'b1, 36'h7F, 3'd1, DEC_OK},
			// Stray continuation byte while idle.
			'{8'h80, EXP_GIVEN, 1'b1, 36'h0, 3'd0, DEC_BAD},
			// Two-byte sequence right at the overlong boundary.
			'{8'hC2, EXP_PREDICT, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_PREDICT, 1'b0, 36'h0, 3'd0, DEC_OK},
			// Overlong two-byte value.
			'{8'hC0, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b1, OverlongCp, 3'd2, DEC_OK},
			// Plain byte and zero byte inside a sequence.
			'{8'hE0, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h41, EXP_GIVEN, 1'b1, 36'h0, 3'd0, DEC_BAD},
			'{8'hE0, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h00, EXP_GIVEN, 1'b1, 36'h0, 3'd0, DEC_BAD},
			// Longest lead with every data bit set.
			'{8'hFF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'hBF, EXP_GIVEN, 1'b1, 36'hF_FFFF_FFFF, 3'd7, DEC_OK},
			// Longest lead with every data bit clear is overlong.
			'{8'hFE, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b0, 36'h0, 3'd0, DEC_OK},
			'{8'h80, EXP_GIVEN, 1'b1, OverlongCp, 3'd7, DEC_OK}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed bytes go first, back to back.
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			byte_q.push_back(directed_rows[i]);
		end
		run_phase(0, 0, 265);
		run_phase(50, 0, 265);
		run_phase(0, 50, 265);
		run_phase(11, 11, 265);

		// Let the last beat go in and every expected result come out.
		while (in_valid || pending_decodes.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
